// File: design/ssr_pkg.sv
// shared types and constants for the streaming find-and-replace block
package ssr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int IN_Q_DEPTH_DEF  = 2;
    localparam int OUT_Q_DEPTH_DEF = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                  valid;
        cfg_reg_t              index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic       eot;
        logic [7:0] ch;
    } in_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       lot;
        logic       lor;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_FLUSH,
        ST_FINISH
    } state_t;

endpackage

// File: design/ssr_fifo.sv
// small first-word-fall-through queue used on both sides of the engine
module ssr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             wr_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             rd_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_full  = (cnt_reg == CW'(DEPTH));
    assign rd_empty = (cnt_reg == '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && !rd_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/ssr_engine.sv
// match engine: pending window, pattern compare and result sequencing
module ssr_engine #(
    parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ssr_pkg::cfg_wr_t   cfg,
    input  logic               in_empty,
    input  ssr_pkg::in_word_t  in_word,
    output logic               in_pop,
    input  logic               out_full,
    output logic               out_push,
    output ssr_pkg::out_word_t out_word
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = $clog2(MAX_PATTERN + 1);

    ssr_pkg::state_t state_reg, state_next;
    logic [63:0]     pat_reg, pat_next;
    logic [3:0]      plen_reg, plen_next;
    logic [63:0]     rep_reg, rep_next;
    logic [3:0]      rlen_reg, rlen_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            hold_v_reg, hold_v_next;

    logic [7:0]      win_reg [MAX_PATTERN];
    logic [7:0]      win_next [MAX_PATTERN];
    logic [7:0]      hold_ch_reg, hold_ch_next;
    logic            eot_reg, eot_next;
    logic [3:0]      idx_reg, idx_next;

    logic [3:0]             plen_eff, rlen_eff, cnt4;
    logic [MAX_PATTERN-1:0] eq, lt;
    logic                   prefix_ok;
    logic                   can_emit;
    logic                   emit_valid;
    logic [7:0]             emit_ch;
    logic [CW-1:0]          wr_pos;

    always_comb
    begin
        if (plen_reg == 4'd0)
        begin
            plen_eff = 4'd1;
        end
        else if (plen_reg > 4'(MAX_PATTERN))
        begin
            plen_eff = 4'(MAX_PATTERN);
        end
        else
        begin
            plen_eff = plen_reg;
        end
        rlen_eff = (rlen_reg > 4'(ssr_pkg::MAX_REPLACEMENT))
                   ? 4'(ssr_pkg::MAX_REPLACEMENT) : rlen_reg;
    end

    assign cnt4 = 4'(cnt_reg);

    // window bytes below the count must equal the pattern prefix
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            eq[i] = (win_reg[i] == pat_reg[8*i +: 8]);
            lt[i] = (CW'(i) < cnt_reg);
        end
    end

    assign prefix_ok = &(eq | ~lt);
    assign can_emit  = !hold_v_reg || !out_full;

    always_comb
    begin
        state_next   = state_reg;
        pat_next     = pat_reg;
        plen_next    = plen_reg;
        rep_next     = rep_reg;
        rlen_next    = rlen_reg;
        cnt_next     = cnt_reg;
        hold_v_next  = hold_v_reg;
        hold_ch_next = hold_ch_reg;
        eot_next     = eot_reg;
        idx_next     = idx_reg;
        win_next     = win_reg;
        in_pop       = 1'b0;
        out_push     = 1'b0;
        out_word     = '0;
        emit_valid   = 1'b0;
        emit_ch      = 8'd0;
        wr_pos       = (cnt4 >= plen_eff) ? '0 : cnt_reg;

        unique case (state_reg)
            ssr_pkg::ST_IDLE:
            begin
                if (!in_empty)
                begin
                    in_pop                = 1'b1;
                    win_next[wr_pos[AW-1:0]] = in_word.ch;
                    cnt_next              = wr_pos + 1'b1;
                    eot_next              = in_word.eot;
                    state_next            = ssr_pkg::ST_SCAN;
                end
            end
            ssr_pkg::ST_SCAN:
            begin
                if (cnt_reg == '0 || (prefix_ok && cnt4 != plen_eff))
                begin
                    state_next = eot_reg ? ssr_pkg::ST_FLUSH : ssr_pkg::ST_FINISH;
                end
                else if (prefix_ok)
                begin
                    idx_next   = 4'd0;
                    state_next = ssr_pkg::ST_REPL;
                end
                else if (can_emit)
                begin
                    // candidate failed: release the oldest byte and look again
                    emit_valid = 1'b1;
                    emit_ch    = win_reg[0];
                    for (int i = 0; i < MAX_PATTERN - 1; i++)
                    begin
                        win_next[i] = win_reg[i+1];
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ssr_pkg::ST_REPL:
            begin
                if (idx_reg < rlen_eff)
                begin
                    if (can_emit)
                    begin
                        emit_valid = 1'b1;
                        emit_ch    = rep_reg[8*idx_reg[2:0] +: 8];
                        idx_next   = idx_reg + 4'd1;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = eot_reg ? ssr_pkg::ST_FLUSH : ssr_pkg::ST_FINISH;
                end
            end
            ssr_pkg::ST_FLUSH:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ssr_pkg::ST_FINISH;
                end
                else if (can_emit)
                begin
                    emit_valid = 1'b1;
                    emit_ch    = win_reg[0];
                    for (int i = 0; i < MAX_PATTERN - 1; i++)
                    begin
                        win_next[i] = win_reg[i+1];
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ssr_pkg::ST_FINISH:
            begin
                // the held word is the last one of this input
                if (hold_v_reg)
                begin
                    if (!out_full)
                    begin
                        out_push    = 1'b1;
                        out_word    = '{ch: hold_ch_reg, has: 1'b1, lot: eot_reg, lor: 1'b1};
                        hold_v_next = 1'b0;
                        state_next  = ssr_pkg::ST_IDLE;
                    end
                end
                else if (eot_reg)
                begin
                    if (!out_full)
                    begin
                        out_push   = 1'b1;
                        out_word   = '{ch: 8'd0, has: 1'b0, lot: 1'b1, lor: 1'b1};
                        state_next = ssr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ssr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssr_pkg::ST_IDLE;
            end
        endcase

        // a new word pushes the previously held one out with no end marks
        if (emit_valid)
        begin
            if (hold_v_reg)
            begin
                out_push = 1'b1;
                out_word = '{ch: hold_ch_reg, has: 1'b1, lot: 1'b0, lor: 1'b0};
            end
            hold_v_next  = 1'b1;
            hold_ch_next = emit_ch;
        end

        if (cfg.valid)
        begin
            unique case (cfg.index)
                ssr_pkg::REG_PATTERN_BYTES:
                begin
                    pat_next = cfg.data;
                end
                ssr_pkg::REG_PATTERN_LENGTH:
                begin
                    plen_next = cfg.data[3:0];
                    cnt_next  = '0;
                end
                ssr_pkg::REG_REPLACEMENT_BYTES:
                begin
                    rep_next = cfg.data;
                end
                ssr_pkg::REG_REPLACEMENT_LENGTH:
                begin
                    rlen_next = cfg.data[3:0];
                end
                default:
                begin
                    pat_next = pat_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ssr_pkg::ST_IDLE;
            pat_reg    <= '0;
            plen_reg   <= 4'd1;
            rep_reg    <= '0;
            rlen_reg   <= 4'd0;
            cnt_reg    <= '0;
            hold_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pat_reg    <= pat_next;
            plen_reg   <= plen_next;
            rep_reg    <= rep_next;
            rlen_reg   <= rlen_next;
            cnt_reg    <= cnt_next;
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg     <= win_next;
        hold_ch_reg <= hold_ch_next;
        eot_reg     <= eot_next;
        idx_reg     <= idx_next;
    end

endmodule

// File: design/stream_substring_replace.sv
// top level: input queue, match engine and result queue
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   input    | push / full          | char_in, end_of_text
//   result   | empty / pop          | char_out, has_char, last_of_text, last_of_run
//   config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// the engine takes one word at a time: it loads the word into the window, releases
// bytes of a failed candidate, ends the scan, emits the replacement after a match,
// flushes the window at end of text and then closes the word; a byte step waits
// while the result queue is full, and a bare end marker goes out in the closing step.
// the input queue holds words while the engine works, the result queue lets the
// consumer stall without stopping the engine until it is full.
// reset empties both queues and the window and loads the register reset values.
module stream_substring_replace #(
    parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
    parameter int IN_DEPTH    = ssr_pkg::IN_Q_DEPTH_DEF,
    parameter int OUT_DEPTH   = ssr_pkg::OUT_Q_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         char_in,
    input  logic                               end_of_text,
    input  logic                               push,
    output logic                               full,
    output logic [7:0]                         char_out,
    output logic                               has_char,
    output logic                               last_of_text,
    output logic                               last_of_run,
    output logic                               empty,
    input  logic                               pop,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IN_W  = $bits(ssr_pkg::in_word_t);
    localparam int OUT_W = $bits(ssr_pkg::out_word_t);

    ssr_pkg::cfg_wr_t   cfg;
    ssr_pkg::in_word_t  in_wr, in_rd;
    ssr_pkg::out_word_t out_wr, out_rd;
    logic               in_empty, in_pop;
    logic               out_full, out_push;

    assign cfg_ready = 1'b1;
    assign cfg       = '{valid: cfg_valid, index: ssr_pkg::cfg_reg_t'(cfg_index),
                         data: cfg_data};
    assign in_wr     = '{eot: end_of_text, ch: char_in};

    ssr_fifo #(
        .WIDTH (IN_W),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (in_wr),
        .wr_full  (full),
        .rd_en    (in_pop),
        .rd_data  (in_rd),
        .rd_empty (in_empty)
    );

    ssr_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_empty (in_empty),
        .in_word  (in_rd),
        .in_pop   (in_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_word (out_wr)
    );

    ssr_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (out_push),
        .wr_data  (out_wr),
        .wr_full  (out_full),
        .rd_en    (pop),
        .rd_data  (out_rd),
        .rd_empty (empty)
    );

    assign char_out     = out_rd.ch;
    assign has_char     = out_rd.has;
    assign last_of_text = out_rd.lot;
    assign last_of_run  = out_rd.lor;

endmodule

// File: tb/tb_top.sv
// self-checking testbench for stream_substring_replace with a built-in rewrite predictor
module tb_top;

    // tracks pattern state and holds the words the block should produce
    class text_rewrite;
        logic [63:0]        pat_bytes;
        logic [63:0]        rep_bytes;
        logic [3:0]         pat_len_reg;
        logic [3:0]         rep_len_reg;
        logic [7:0]         window [ssr_pkg::MAX_PATTERN_DEF];
        int unsigned        held;
        ssr_pkg::out_word_t rewritten_words [$];
        int unsigned        mismatches;

        function new();
            pat_bytes = '0;
            rep_bytes = '0;
            pat_len_reg = 4'd1;
            rep_len_reg = 4'd0;
            held = 0;
            mismatches = 0;
        endfunction

        function int unsigned pattern_len();
            if (pat_len_reg == 4'd0)
                return 1;
            if (pat_len_reg > ssr_pkg::MAX_PATTERN_DEF)
                return ssr_pkg::MAX_PATTERN_DEF;
            return pat_len_reg;
        endfunction

        function int unsigned replace_len();
            if (rep_len_reg > ssr_pkg::MAX_REPLACEMENT)
                return ssr_pkg::MAX_REPLACEMENT;
            return rep_len_reg;
        endfunction

        function bit prefix_ok(int unsigned cnt);
            for (int unsigned i = 0; i < cnt; i++)
                if (window[i] != pat_bytes[8*i +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void write_register(ssr_pkg::cfg_reg_t idx, logic [63:0] value);
            case (idx)
                ssr_pkg::REG_PATTERN_BYTES:
                begin
                    pat_bytes = value;
                end
                ssr_pkg::REG_PATTERN_LENGTH:
                begin
                    pat_len_reg = value[3:0];
                    held = 0;
                end
                ssr_pkg::REG_REPLACEMENT_BYTES:
                begin
                    rep_bytes = value;
                end
                ssr_pkg::REG_REPLACEMENT_LENGTH:
                begin
                    rep_len_reg = value[3:0];
                end
                default:
                begin
                end
            endcase
        endfunction

        function void take_byte(logic [7:0] ch, logic eot);
            ssr_pkg::out_word_t run [$];
            ssr_pkg::out_word_t w;
            int unsigned        plen;
            int unsigned        i;
            plen = pattern_len();
            if (held >= plen)
                held = 0;
            window[held] = ch;
            held++;
            while (held > 0)
            begin
                if (held == plen && prefix_ok(plen))
                begin
                    for (i = 0; i < replace_len(); i++)
                    begin
                        w = '{ch: rep_bytes[8*i +: 8], has: 1'b1, lot: 1'b0, lor: 1'b0};
                        run.push_back(w);
                    end
                    held = 0;
                    break;
                end
                if (held < plen && prefix_ok(held))
                    break;
                // candidate failed: release the oldest byte and rescan the rest
                w = '{ch: window[0], has: 1'b1, lot: 1'b0, lor: 1'b0};
                run.push_back(w);
                for (i = 1; i < held; i++)
                    window[i-1] = window[i];
                held--;
            end
            if (eot)
            begin
                for (i = 0; i < held; i++)
                begin
                    w = '{ch: window[i], has: 1'b1, lot: 1'b0, lor: 1'b0};
                    run.push_back(w);
                end
                held = 0;
                if (run.size() == 0)
                begin
                    w = '{ch: 8'h00, has: 1'b0, lot: 1'b0, lor: 1'b0};
                    run.push_back(w);
                end
                run[run.size()-1].lot = 1'b1;
            end
            if (run.size() > 0)
                run[run.size()-1].lor = 1'b1;
            for (i = 0; i < run.size(); i++)
                rewritten_words.push_back(run[i]);
        endfunction

        function void check_word(ssr_pkg::out_word_t got);
            ssr_pkg::out_word_t want;
            if (rewritten_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: char_out %h has %b lot %b lor %b",
                             got.ch, got.has, got.lot, got.lor);
                return;
            end
            want = rewritten_words.pop_front();
            if (got.ch !== want.ch || got.has !== want.has ||
                got.lot !== want.lot || got.lor !== want.lor)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected char %h has %b lot %b lor %b, ",
                             want.ch, want.has, want.lot, want.lor,
                             "got char %h has %b lot %b lor %b",
                             got.ch, got.has, got.lot, got.lor);
            end
        endfunction

        function int unsigned waiting();
            return rewritten_words.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic [7:0]                     char_in = 8'h00;
    logic                           end_of_text = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [7:0]                     char_out;
    logic                           has_char;
    logic                           last_of_text;
    logic                           last_of_run;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    ssr_pkg::cfg_reg_t              cfg_index = ssr_pkg::REG_PATTERN_BYTES;
    logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    text_rewrite rewrite = new();
    int unsigned burst_left = 0;
    int unsigned hold_asks = 0;

    stream_substring_replace i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_in      (char_in),
        .end_of_text  (end_of_text),
        .push         (push),
        .full         (full),
        .char_out     (char_out),
        .has_char     (has_char),
        .last_of_text (last_of_text),
        .last_of_run  (last_of_run),
        .empty        (empty),
        .pop          (pop),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_word(input logic [7:0] ch, input logic eot);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        push <= 1'b1;
        char_in <= ch;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (full);
        rewrite.take_byte(ch, eot);
        burst_left--;
    endtask

    // bytes go out lowest first, eot marks the last one
    task automatic send_bytes(input logic [63:0] s, input int unsigned n, input logic eot);
        for (int unsigned i = 0; i < n; i++)
            send_word(s[8*i +: 8], eot && (i == n - 1));
    endtask

    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        while (rewrite.waiting() != 0)
            @(posedge clk);
        // a trailing word may still be in the engine without any result
        repeat (60) @(posedge clk);
    endtask

    task automatic write_registers(input logic [63:0] pb, input logic [63:0] pl,
                                   input logic [63:0] rb, input logic [63:0] rl);
        ssr_pkg::cfg_reg_t order [4];
        logic [63:0]       vals [4];
        order = '{ssr_pkg::REG_PATTERN_BYTES, ssr_pkg::REG_PATTERN_LENGTH,
                  ssr_pkg::REG_REPLACEMENT_BYTES, ssr_pkg::REG_REPLACEMENT_LENGTH};
        vals = '{pb, pl, rb, rl};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[k];
            cfg_data <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            rewrite.write_register(order[k], vals[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0]  text [$];
        logic [7:0]  alphabet [3];
        logic [63:0] pb;
        logic [63:0] rb;
        logic [63:0] pl;
        logic [63:0] rl;
        int unsigned sent;
        int unsigned plen;
        int unsigned cut;
        int unsigned k;
        int unsigned j;
        int unsigned p;
        int unsigned asz;
        int unsigned choice;
        bit          noise;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: single zero byte deleted, bare end marker
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b1);
        settle();

        // overlapping prefix "aba" -> "XY", then a lone partial match at end of text
        write_registers(64'h616261, 64'd3, 64'h5958, 64'd2);
        send_bytes(64'h616261626161, 6, 1'b1);
        send_bytes(64'h61, 1, 1'b1);
        settle();

        // longest pattern and replacement, then a chain of releases
        write_registers(64'h8001fe7f00ff55aa, 64'd8, 64'h0123456789abcdef, 64'd8);
        send_bytes(64'h8001fe7f00ff55aa, 8, 1'b0);
        send_bytes(64'h33ff55aa, 4, 1'b1);
        settle();

        // out-of-range lengths are clamped
        write_registers(64'h7a, 64'd0, 64'h7978777675747372, 64'd15);
        send_bytes(64'h7a717a, 3, 1'b1);
        settle();

        for (p = 0; p < 7; p++)
        begin
            asz = (p == 3) ? 2 : 3;
            for (k = 0; k < 3; k++)
                alphabet[k] = 8'($urandom);
            for (k = 0; k < 8; k++)
                pb[8*k +: 8] = alphabet[$urandom_range(0, asz - 1)];
            if (p == 6)
                pb = {$urandom, $urandom};
            rb = {$urandom, $urandom};
            case (p)
                0:
                begin
                    pl = 64'd8;
                    rl = 64'd0;
                end
                1:
                begin
                    pl = 64'd1;
                    rl = 64'd8;
                end
                2:
                begin
                    pl = 64'd13;
                    rl = 64'd11;
                end
                default:
                begin
                    pl = 64'($urandom_range(1, 8));
                    rl = 64'($urandom_range(0, 8));
                end
            endcase
            // only the low nibble of a length counts
            if (p >= 4)
            begin
                pl = ({$urandom, $urandom} & ~64'hf) | pl;
                rl = ({$urandom, $urandom} & ~64'hf) | rl;
            end
            write_registers(pb, pl, rb, rl);
            if (p == 2)
                hold_asks <= hold_asks + 1;

            sent = 0;
            while (sent < 18)
            begin
                text.delete();
                plen = rewrite.pattern_len();
                noise = ($urandom_range(0, 9) == 0);
                cut = $urandom_range(1, 14);
                while (text.size() < cut)
                begin
                    choice = noise ? 9 : $urandom_range(0, 9);
                    case (choice)
                        0, 1, 2, 3:
                        begin
                            for (k = 0; k < plen; k++)
                                text.push_back(rewrite.pat_bytes[8*k +: 8]);
                        end
                        4, 5:
                        begin
                            j = $urandom_range(1, plen);
                            for (k = 0; k < j; k++)
                                text.push_back(rewrite.pat_bytes[8*k +: 8]);
                        end
                        6, 7, 8:
                        begin
                            text.push_back(alphabet[$urandom_range(0, 2)]);
                        end
                        default:
                        begin
                            text.push_back(8'($urandom));
                        end
                    endcase
                end
                for (k = 0; k < text.size(); k++)
                    send_word(text[k], k == text.size() - 1);
                sent += text.size();
            end
            settle();
        end

        k = 0;
        while (rewrite.waiting() != 0 && k < 20000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (60) @(posedge clk);
        rewrite.mismatches += rewrite.waiting();
        if (rewrite.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : receiver
        logic [15:0]        stall_mask;
        int unsigned        tick;
        int unsigned        hold_done;
        ssr_pkg::out_word_t got;
        stall_mask = '1;
        tick = 0;
        hold_done = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.ch = char_out;
                got.has = has_char;
                got.lot = last_of_text;
                got.lor = last_of_run;
                rewrite.check_word(got);
            end
            if (hold_done != hold_asks)
            begin
                // long hold-off so the block backs up into its input
                pop <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done++;
            end
            else
            begin
                if (tick % 64 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       stall_mask = '1;
                        1:       stall_mask = 16'($urandom);
                        2:       stall_mask = 16'($urandom & $urandom);
                        default: stall_mask = 16'($urandom | $urandom);
                    endcase
                end
                pop <= stall_mask[tick % 16];
                tick++;
            end
        end
    end

    initial
    begin
        #(12 * 400000);
        $display("tb: failure");
        $finish;
    end

endmodule
